// ===== sv/dlpr_pkg.sv =====
// Shared types, codes and helpers for the debug link packet receiver.
package dlpr_pkg;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HEX_HI  = 2'd2;
  localparam logic [1:0] PH_HEX_LO  = 2'd3;

  localparam logic [2:0] EV_ACK       = 3'd0;
  localparam logic [2:0] EV_RESEND    = 3'd1;
  localparam logic [2:0] EV_INTERRUPT = 3'd2;
  localparam logic [2:0] EV_BYTE      = 3'd3;
  localparam logic [2:0] EV_OK        = 3'd4;
  localparam logic [2:0] EV_BADSUM    = 3'd5;
  localparam logic [2:0] EV_FRAMING   = 3'd6;

  localparam logic [7:0] CH_ACK    = 8'h2B;  // '+'
  localparam logic [7:0] CH_RESEND = 8'h2D;  // '-'
  localparam logic [7:0] CH_INTR   = 8'h03;
  localparam logic [7:0] CH_START  = 8'h24;  // '$'
  localparam logic [7:0] CH_END    = 8'h23;  // '#'
  localparam logic [7:0] CH_ESC    = 8'h7D;  // '}'
  localparam logic [7:0] ESC_XOR   = 8'h20;

  typedef struct packed {
    logic [1:0] phase;
    logic       escape_pending;
    logic [7:0] running_sum;
    logic [3:0] check_high_nibble;
  } rx_state_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [7:0] data;
  } rx_event_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'h10;
    d = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      r = {1'b0, d[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
      r = {1'b0, d[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== sv/dlpr_rx_if.sv =====
// Channel carrying received serial bytes.
interface dlpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/dlpr_ev_if.sv =====
// Channel carrying decoded receiver events.
interface dlpr_ev_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] event_data;

  modport source (output valid, output event_kind, output event_data, input ready);
  modport sink (input valid, input event_kind, input event_data, output ready);
endinterface

// ===== sv/dlpr_step.sv =====
// Per-byte state update and event decode of the packet receiver.
module dlpr_step
  import dlpr_pkg::*;
(
  input  rx_state_t  st,
  input  logic [7:0] rx_byte,
  output rx_state_t  st_next,
  output rx_event_t  ev
);

  logic [4:0] hv;
  logic [7:0] sum_add;
  logic [7:0] rx_sum;

  assign hv      = hex_value(rx_byte);
  assign sum_add = st.running_sum + rx_byte;
  assign rx_sum  = {st.check_high_nibble, hv[3:0]};

  always_comb begin
    st_next = st;
    ev      = '0;
    case (st.phase)
      PH_PAYLOAD: begin
        if (rx_byte == CH_START) begin
          st_next = '0;
          st_next.phase = PH_PAYLOAD;
        end else if (rx_byte == CH_END) begin
          st_next.escape_pending = 1'b0;
          st_next.phase = PH_HEX_HI;
        end else begin
          st_next.running_sum = sum_add;
          if (st.escape_pending) begin
            st_next.escape_pending = 1'b0;
            ev = '{emit: 1'b1, kind: EV_BYTE, data: rx_byte ^ ESC_XOR};
          end else if (rx_byte == CH_ESC) begin
            st_next.escape_pending = 1'b1;
          end else begin
            ev = '{emit: 1'b1, kind: EV_BYTE, data: rx_byte};
          end
        end
      end
      PH_HEX_HI: begin
        if (hv[4]) begin
          st_next.phase = PH_IDLE;
          ev = '{emit: 1'b1, kind: EV_FRAMING, data: st.running_sum};
        end else begin
          st_next.check_high_nibble = hv[3:0];
          st_next.phase = PH_HEX_LO;
        end
      end
      PH_HEX_LO: begin
        st_next.phase = PH_IDLE;
        if (hv[4]) begin
          ev = '{emit: 1'b1, kind: EV_FRAMING, data: st.running_sum};
        end else if (rx_sum == st.running_sum) begin
          ev = '{emit: 1'b1, kind: EV_OK, data: st.running_sum};
        end else begin
          ev = '{emit: 1'b1, kind: EV_BADSUM, data: st.running_sum};
        end
      end
      default: begin
        st_next.phase = PH_IDLE;
        if (rx_byte == CH_ACK) begin
          ev = '{emit: 1'b1, kind: EV_ACK, data: 8'h00};
        end else if (rx_byte == CH_RESEND) begin
          ev = '{emit: 1'b1, kind: EV_RESEND, data: 8'h00};
        end else if (rx_byte == CH_INTR) begin
          ev = '{emit: 1'b1, kind: EV_INTERRUPT, data: 8'h00};
        end else if (rx_byte == CH_START) begin
          st_next = '0;
          st_next.phase = PH_PAYLOAD;
        end
      end
    endcase
  end

endmodule

// ===== sv/debug_link_packet_receiver_core.sv =====
// Top level of the debug link packet receiver: input stage, decode, event register.
// Takes one received byte per word and reports at most one event per byte: ack,
// resend, interrupt, unescaped payload byte, or packet ok / checksum error /
// framing error with the computed checksum. A byte is accepted every cycle
// while events are drained; an event shows valid on the output once its byte
// has been taken into the input register and then decoded into the event
// register by the state update. Bytes that produce no event never block
// the input. A held event stalls the input only when the byte behind it also
// produces an event.
module debug_link_packet_receiver_core
  import dlpr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  dlpr_rx_if.sink       rx,
  dlpr_ev_if.source     events
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  rx_state_t  st;
  rx_state_t  st_next;
  rx_event_t  ev_c;
  logic       ev_valid;
  logic [2:0] ev_kind;
  logic [7:0] ev_data;
  logic       out_free;
  logic       s1_adv;
  logic       s1_take;

  dlpr_step u_step (
    .st      (st),
    .rx_byte (s1_byte),
    .st_next (st_next),
    .ev      (ev_c)
  );

  assign out_free = !ev_valid || events.ready;
  assign s1_adv   = !ev_c.emit || out_free;
  assign s1_take  = s1_valid && s1_adv;
  assign rx.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, escape_pending: 1'b0, running_sum: 8'h00,
              check_high_nibble: 4'h0};
    end else if (s1_take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (out_free) begin
      ev_valid <= s1_take && ev_c.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_take && ev_c.emit) begin
      ev_kind <= ev_c.kind;
      ev_data <= ev_c.data;
    end
  end

  assign events.valid      = ev_valid;
  assign events.event_kind = ev_kind;
  assign events.event_data = ev_data;

  // pending event with a full output must stay in the input stage
  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    s1_valid && ev_c.emit && !out_free |=> s1_valid && $stable(s1_byte))
    else $error("pending event dropped from input stage");

  // a consumed byte with an event shows up at the output
  a_event_out: assert property (@(posedge clk) disable iff (rst)
    s1_take && ev_c.emit |=> events.valid)
    else $error("event lost on its way to output register");

  // escape flag only lives inside a payload
  a_escape_phase: assert property (@(posedge clk) disable iff (rst)
    st.escape_pending |-> st.phase == PH_PAYLOAD)
    else $error("escape pending outside payload");

  // empty input stage always takes a word
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> rx.ready)
    else $error("input stalled while empty");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the debug link packet receiver: directed table plus random packets.
module testbench;
  import dlpr_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_LIMIT   = 400;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_GAP      = 11;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
  } event_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    bit         fires;
    logic [2:0] kind;
    logic [7:0] data;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dlpr_rx_if rx_ch ();
  dlpr_ev_if ev_ch ();

  debug_link_packet_receiver_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .events (ev_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver state as seen from outside
  logic [1:0] rx_phase;
  logic       esc_armed;
  logic [7:0] pkt_sum;
  logic [3:0] hi_nibble;

  event_t expected_events[$];
  int     mismatch_count = 0;
  int     sent_items = 0;
  int     idle_cycles = 0;
  bit     tx_steady = 1'b0;
  bit     drain_steady = 1'b0;

  // rows marked typed carry their expected event; the rest use the tracker
  stim_row_t directed_rows [29] = '{
    '{CH_ACK,    1'b1, 1'b1, EV_ACK,       8'h00},
    '{CH_RESEND, 1'b1, 1'b1, EV_RESEND,    8'h00},
    '{CH_INTR,   1'b1, 1'b1, EV_INTERRUPT, 8'h00},
    '{8'h00,     1'b1, 1'b0, EV_ACK,       8'h00},
    '{CH_START,  1'b1, 1'b0, EV_ACK,       8'h00},
    '{CH_END,    1'b1, 1'b0, EV_ACK,       8'h00},
    '{8'h30,     1'b1, 1'b0, EV_ACK,       8'h00},
    '{8'h30,     1'b1, 1'b1, EV_OK,        8'h00},
    '{CH_START,  1'b1, 1'b0, EV_ACK,       8'h00},
    '{8'hFF,     1'b1, 1'b1, EV_BYTE,      8'hFF},
    '{CH_ESC,    1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h5D,     1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_START,  1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_ESC,    1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_END,    1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h37,     1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h64,     1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_START,  1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h41,     1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_END,    1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h34,     1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h32,     1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_START,  1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_END,    1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h67,     1'b1, 1'b1, EV_FRAMING,   8'h00},
    '{CH_START,  1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_END,    1'b0, 1'b0, EV_ACK,       8'h00},
    '{8'h61,     1'b0, 1'b0, EV_ACK,       8'h00},
    '{CH_START,  1'b1, 1'b1, EV_FRAMING,   8'h00}
  };

  // bit 4 high when the byte is a hex digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b1, c[3:0] + 4'd9};
    return 5'h00;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_START || b == CH_END);
    return b;
  endfunction

  task automatic track_byte(input logic [7:0] b, output bit fires,
                            output logic [2:0] kind, output logic [7:0] data);
    logic [4:0] d;
    fires = 1'b0;
    kind = EV_ACK;
    data = 8'h00;
    d = digit_value(b);
    case (rx_phase)
      PH_PAYLOAD: begin
        if (b == CH_START) begin
          esc_armed = 1'b0;
          pkt_sum = 8'h00;
          hi_nibble = 4'h0;
        end else if (b == CH_END) begin
          esc_armed = 1'b0;
          rx_phase = PH_HEX_HI;
        end else begin
          pkt_sum = pkt_sum + b;
          if (esc_armed) begin
            esc_armed = 1'b0;
            fires = 1'b1;
            kind = EV_BYTE;
            data = b ^ ESC_XOR;
          end else if (b == CH_ESC) begin
            esc_armed = 1'b1;
          end else begin
            fires = 1'b1;
            kind = EV_BYTE;
            data = b;
          end
        end
      end
      PH_HEX_HI: begin
        if (!d[4]) begin
          rx_phase = PH_IDLE;
          fires = 1'b1;
          kind = EV_FRAMING;
          data = pkt_sum;
        end else begin
          hi_nibble = d[3:0];
          rx_phase = PH_HEX_LO;
        end
      end
      PH_HEX_LO: begin
        rx_phase = PH_IDLE;
        fires = 1'b1;
        data = pkt_sum;
        if (!d[4]) kind = EV_FRAMING;
        else if ({hi_nibble, d[3:0]} == pkt_sum) kind = EV_OK;
        else kind = EV_BADSUM;
      end
      default: begin
        rx_phase = PH_IDLE;
        if (b == CH_ACK) begin
          fires = 1'b1;
          kind = EV_ACK;
        end else if (b == CH_RESEND) begin
          fires = 1'b1;
          kind = EV_RESEND;
        end else if (b == CH_INTR) begin
          fires = 1'b1;
          kind = EV_INTERRUPT;
        end else if (b == CH_START) begin
          rx_phase = PH_PAYLOAD;
          esc_armed = 1'b0;
          pkt_sum = 8'h00;
          hi_nibble = 4'h0;
        end
      end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_fires,
                           input logic [2:0] typed_kind, input logic [7:0] typed_data);
    int         gap;
    bit         fires;
    logic [2:0] kind;
    logic [7:0] data;
    event_t     ev;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    track_byte(b, fires, kind, data);
    if (typed) begin
      fires = typed_fires;
      kind = typed_kind;
      data = typed_data;
    end
    if (fires) begin
      ev.kind = kind;
      ev.data = data;
      expected_events.push_back(ev);
    end
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_packet(input bit broken);
    logic [7:0] frame[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         len;
    frame.push_back(CH_START);
    sum = 8'h00;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        frame.push_back(CH_ESC);
        sum = sum + CH_ESC;
      end
      b = payload_byte();
      frame.push_back(b);
      sum = sum + b;
    end
    if (!broken && $urandom_range(0, 7) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    frame.push_back(CH_END);
    frame.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
    frame.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
    if (broken) begin
      case ($urandom_range(0, 2))
        0: frame[frame.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
        1: frame.insert($urandom_range(1, frame.size() - 3), CH_START);
        default: frame.insert(frame.size() - 3, CH_ESC);
      endcase
    end
    tx_steady = ($urandom_range(0, 3) == 0);
    foreach (frame[i]) send_byte(frame[i], 1'b0, 1'b0, EV_ACK, 8'h00);
  endtask

  initial begin
    int pick;
    rx_phase = PH_IDLE;
    esc_armed = 1'b0;
    pkt_sum = 8'h00;
    hi_nibble = 4'h0;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].fires,
                directed_rows[i].kind, directed_rows[i].data);

    while (sent_items < $size(directed_rows) + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        send_packet(1'b0);
      end else if (pick == 7) begin
        send_packet(1'b1);
      end else begin
        tx_steady = ($urandom_range(0, 1) == 0);
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0: send_byte(CH_ACK, 1'b0, 1'b0, EV_ACK, 8'h00);
            1: send_byte(CH_RESEND, 1'b0, 1'b0, EV_ACK, 8'h00);
            2: send_byte(CH_INTR, 1'b0, 1'b0, EV_ACK, 8'h00);
            default: send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, EV_ACK, 8'h00);
          endcase
        end
      end
    end

    rx_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("debug_link_packet_receiver_core: match");
    else
      $display("debug_link_packet_receiver_core: mismatch");
    $finish;
  end

  initial begin
    int stall;
    ev_ch.ready <= 1'b0;
    repeat (4) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) drain_steady = ~drain_steady;
      stall = drain_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        ev_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      ev_ch.ready <= 1'b1;
      do @(posedge clk); while (!ev_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    event_t want;
    if (!rst && ev_ch.valid && ev_ch.ready) begin
      if (expected_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: event expected none actual kind %0d data 0x%02h",
                 $time, ev_ch.event_kind, ev_ch.event_data);
      end else begin
        want = expected_events.pop_front();
        if (ev_ch.event_kind !== want.kind) begin
          mismatch_count++;
          $display("%0t: event_kind expected %0d actual %0d",
                   $time, want.kind, ev_ch.event_kind);
        end
        if (ev_ch.event_data !== want.data) begin
          mismatch_count++;
          $display("%0t: event_data expected 0x%02h actual 0x%02h",
                   $time, want.data, ev_ch.event_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (ev_ch.valid && ev_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("debug_link_packet_receiver_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
